### hw/rtl/fbfl_pkg.sv
package fbfl_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int BLK_IDX_W     = $clog2(MAX_BLOCKS);
    localparam int LINK_W        = BLK_IDX_W + 1;
    localparam int WORD_BYTES    = 8;
    localparam int WORD_SHIFT    = $clog2(WORD_BYTES);
    localparam int NUM_BLOCKS_W  = 9;
    localparam int BLOCK_BYTES_W = 13;
    localparam int WORDS_W       = BLOCK_BYTES_W + 1 - WORD_SHIFT;
    localparam int PROD_W        = BLK_IDX_W + WORDS_W;
    localparam int OFFSET_W      = 17;
    localparam int CNT_W         = 9;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CNT_W-1:0]        CNT_MAX         = '1;
    localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_MAX  = NUM_BLOCKS_W'(MAX_BLOCKS);
    localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RST  = NUM_BLOCKS_W'(256);
    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RST = BLOCK_BYTES_W'(8);

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_BLOCKS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES = 1'd1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [BLK_IDX_W-1:0] block_index;
    } in_word_t;

    typedef struct packed {
        logic                 ok;
        logic [BLK_IDX_W-1:0] alloc_index;
        logic [OFFSET_W-1:0]  word_offset;
        logic [CNT_W-1:0]     free_count;
    } out_word_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic free_push;
        logic alloc_read;
        logic alloc_pop;
        logic set_fail;
        logic init_start;
        logic init_empty;
        logic init_step;
        logic load_out;
    } dp_ctl_t;

    typedef struct packed {
        logic head_empty;
        logic n_zero;
        logic init_last;
        logic out_free;
    } dp_sts_t;

endpackage

### hw/rtl/fixed_block_free_list_allocator_unit.sv
// Fixed-size block allocator: a free list of up to 256 equal blocks, linked
// through a single-port-write, registered-read link memory with a head
// register and a running free counter. Commands: init (0) relinks blocks
// 0 to num_blocks-1 in order, alloc (1) pops the head, free (2) pushes
// block_index. One result word per command, carrying the allocated index,
// its word offset (1 + index * block words of 8 bytes) and the free count.
// One command is processed at a time; the next is taken once the result
// has entered the output register. Alloc reads the link memory, then updates
// the head; init writes one link per block in order. The list is empty after
// reset until the first init or free; write num_blocks and block_bytes only
// while idle.
module fixed_block_free_list_allocator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fbfl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  fbfl_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output fbfl_pkg::out_word_t              out_data
);

    fbfl_pkg::dp_ctl_t ctl;
    fbfl_pkg::dp_sts_t sts;

    fbfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    fbfl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_index  (in_data.block_index),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/fbfl_ctrl.sv
module fbfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_cmd,
    output logic              in_stall,
    input  fbfl_pkg::dp_sts_t sts,
    output fbfl_pkg::dp_ctl_t ctl
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INIT   = 4'b0010,
        ST_ALLOC  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESULT;
                    case (in_cmd)
                        fbfl_pkg::CMD_INIT:
                        begin
                            if (sts.n_zero)
                            begin
                                ctl.init_empty = 1'b1;
                            end
                            else
                            begin
                                ctl.init_start = 1'b1;
                                state_next     = ST_INIT;
                            end
                        end
                        fbfl_pkg::CMD_ALLOC:
                        begin
                            if (sts.head_empty)
                            begin
                                ctl.set_fail = 1'b1;
                            end
                            else
                            begin
                                ctl.alloc_read = 1'b1;
                                state_next     = ST_ALLOC;
                            end
                        end
                        fbfl_pkg::CMD_FREE:
                        begin
                            ctl.free_push = 1'b1;
                        end
                        default:
                        begin
                            ctl.set_fail = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                ctl.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_ALLOC:
            begin
                ctl.alloc_pop = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold the result until the output register can take it
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start processing");

    a_alloc_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |=> (state_reg == ST_RESULT))
        else $error("pop did not move on to the result");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> sts.out_free)
        else $error("result loaded while the output register is occupied");

endmodule

### hw/rtl/fbfl_dp.sv
module fbfl_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [fbfl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [fbfl_pkg::BLK_IDX_W-1:0]         in_index,
    input  fbfl_pkg::dp_ctl_t                      ctl,
    output fbfl_pkg::dp_sts_t                      sts,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output fbfl_pkg::out_word_t                    out_data
);

    logic [fbfl_pkg::NUM_BLOCKS_W-1:0]  num_blocks_reg;
    logic [fbfl_pkg::BLOCK_BYTES_W-1:0] block_bytes_reg;
    logic [fbfl_pkg::LINK_W-1:0]        head_reg;
    logic [fbfl_pkg::LINK_W-1:0]        head_next;
    logic [fbfl_pkg::CNT_W-1:0]         cnt_reg;
    logic [fbfl_pkg::CNT_W-1:0]         cnt_next;
    logic [fbfl_pkg::BLK_IDX_W-1:0]     walk_reg;
    logic [fbfl_pkg::NUM_BLOCKS_W-1:0]  n_reg;
    logic [fbfl_pkg::BLK_IDX_W-1:0]     blk_reg;
    logic                               res_ok_reg;
    logic [fbfl_pkg::BLK_IDX_W-1:0]     res_idx_reg;
    logic [fbfl_pkg::OFFSET_W-1:0]      res_off_reg;
    logic                               out_valid_reg;
    fbfl_pkg::out_word_t                out_data_reg;

    logic [fbfl_pkg::LINK_W-1:0]        link_mem [fbfl_pkg::MAX_BLOCKS];
    logic [fbfl_pkg::LINK_W-1:0]        rd_data_reg;
    logic                               mem_we;
    logic [fbfl_pkg::BLK_IDX_W-1:0]     mem_waddr;
    logic [fbfl_pkg::LINK_W-1:0]        mem_wdata;
    logic [fbfl_pkg::BLK_IDX_W-1:0]     head_blk;

    logic [fbfl_pkg::NUM_BLOCKS_W-1:0]  n_sat;
    logic [fbfl_pkg::NUM_BLOCKS_W-1:0]  walk_plus1;
    logic                               walk_last;
    logic [fbfl_pkg::BLOCK_BYTES_W:0]   bytes_up;
    logic [fbfl_pkg::WORDS_W-1:0]       block_words;
    logic [fbfl_pkg::PROD_W-1:0]        prod;

    assign n_sat = (num_blocks_reg > fbfl_pkg::NUM_BLOCKS_MAX) ?
                   fbfl_pkg::NUM_BLOCKS_MAX : num_blocks_reg;
    assign walk_plus1 = fbfl_pkg::NUM_BLOCKS_W'(walk_reg) + 1'b1;
    assign walk_last  = (walk_plus1 == n_reg);
    assign head_blk   = fbfl_pkg::BLK_IDX_W'(head_reg - 1'b1);

    // round the block size up to whole words
    assign bytes_up    = {1'b0, block_bytes_reg} +
                         (fbfl_pkg::BLOCK_BYTES_W + 1)'(fbfl_pkg::WORD_BYTES - 1);
    assign block_words = bytes_up[fbfl_pkg::BLOCK_BYTES_W:fbfl_pkg::WORD_SHIFT];
    assign prod        = fbfl_pkg::PROD_W'(blk_reg) * fbfl_pkg::PROD_W'(block_words);

    assign sts.head_empty = (head_reg == '0);
    assign sts.n_zero     = (num_blocks_reg == '0);
    assign sts.init_last  = walk_last;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_reg;
        mem_wdata = '0;
        if (ctl.free_push)
        begin
            mem_we    = 1'b1;
            mem_waddr = in_index;
            mem_wdata = head_reg;
        end
        else if (ctl.init_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = walk_reg;
            // tail of the list links to nothing
            mem_wdata = walk_last ? '0 : fbfl_pkg::LINK_W'(walk_plus1) + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.alloc_read)
        begin
            rd_data_reg <= link_mem[head_blk];
        end
    end

    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (ctl.free_push)
        begin
            head_next = fbfl_pkg::LINK_W'(in_index) + 1'b1;
            cnt_next  = (cnt_reg == fbfl_pkg::CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        end
        else if (ctl.alloc_pop)
        begin
            head_next = rd_data_reg;
            cnt_next  = (cnt_reg == '0) ? cnt_reg : cnt_reg - 1'b1;
        end
        else if (ctl.init_empty)
        begin
            head_next = '0;
            cnt_next  = '0;
        end
        else if (ctl.init_step && walk_last)
        begin
            head_next = fbfl_pkg::LINK_W'(1);
            cnt_next  = fbfl_pkg::CNT_W'(n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg  <= fbfl_pkg::NUM_BLOCKS_RST;
            block_bytes_reg <= fbfl_pkg::BLOCK_BYTES_RST;
            head_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    fbfl_pkg::REG_NUM_BLOCKS:
                    begin
                        num_blocks_reg <= cfg_data[fbfl_pkg::NUM_BLOCKS_W-1:0];
                    end
                    fbfl_pkg::REG_BLOCK_BYTES:
                    begin
                        block_bytes_reg <= cfg_data[fbfl_pkg::BLOCK_BYTES_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init_start)
        begin
            walk_reg <= '0;
            n_reg    <= n_sat;
        end
        else if (ctl.init_step)
        begin
            walk_reg <= walk_reg + 1'b1;
        end
        if (ctl.alloc_read)
        begin
            blk_reg <= head_blk;
        end
        if (ctl.alloc_pop)
        begin
            res_ok_reg  <= 1'b1;
            res_idx_reg <= blk_reg;
            res_off_reg <= prod[fbfl_pkg::OFFSET_W-1:0] + 1'b1;
        end
        else if (ctl.free_push || ctl.init_empty || ctl.init_step)
        begin
            res_ok_reg  <= 1'b1;
            res_idx_reg <= '0;
            res_off_reg <= '0;
        end
        else if (ctl.set_fail)
        begin
            res_ok_reg  <= 1'b0;
            res_idx_reg <= '0;
            res_off_reg <= '0;
        end
        if (ctl.load_out)
        begin
            out_data_reg.ok          <= res_ok_reg;
            out_data_reg.alloc_index <= res_idx_reg;
            out_data_reg.word_offset <= res_off_reg;
            out_data_reg.free_count  <= cnt_reg;
        end
    end

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc_read |-> (head_reg != '0))
        else $error("link read issued on an empty list");

    a_push_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.free_push |=> (head_reg != '0))
        else $error("list empty after a push");

    a_init_head: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.init_step && walk_last) |=> (head_reg == fbfl_pkg::LINK_W'(1)))
        else $error("list head not at block zero after the init walk");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
